// ===== design/gecs_pkg.sv =====
// Shared types and constants for the gradient edge crossing select block.
`default_nettype none
package gecs_pkg;

  typedef enum logic [2:0] {
    PICK_END0   = 3'd0,
    PICK_END1   = 3'd1,
    PICK_PLANE0 = 3'd2,
    PICK_PLANE1 = 3'd3,
    PICK_LINEAR = 3'd4
  } pick_e;

  // Which numerator/denominator pair the back end divides, and how to finish.
  typedef enum logic [1:0] {
    DIV_NONE  = 2'd0,  // fraction already known
    DIV_PLAIN = 2'd1,  // fraction = quotient
    DIV_INV   = 2'd2,  // fraction = one - quotient
    DIV_BOTH  = 2'd3   // both planes on the edge, sign rule picks
  } div_mode_e;

endpackage
`default_nettype wire

// ===== design/gecs_front.sv =====
// Front end: classifies one edge and prepares a single divide job.
`default_nettype none
module gecs_front #(
  parameter int FRACTION_BITS = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] iso_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] s0_i,
  input  logic signed [SAMPLE_BITS-1:0] s1_i,
  input  logic signed [SAMPLE_BITS-1:0] g0_i,
  input  logic signed [SAMPLE_BITS-1:0] g1_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output logic [SAMPLE_BITS:0]          job_num_a_o,
  output logic [SAMPLE_BITS:0]          job_den_a_o,
  output logic [SAMPLE_BITS:0]          job_num_o,
  output logic [SAMPLE_BITS:0]          job_den_o,
  output logic [1:0]                    job_mode_o,
  output logic [FRACTION_BITS:0]        job_frac_o,
  output logic [2:0]                    job_pick_o,
  output logic                          job_degen_o
);
  import gecs_pkg::*;

  localparam int W = SAMPLE_BITS + 2;
  localparam logic [FRACTION_BITS:0] One = {1'b1, {FRACTION_BITS{1'b0}}};

  // Stage 1 registers: differences, gradients and comparison flags.
  logic              v1_q;
  logic signed [W-1:0] sd0_q, sd1_q, ng1_q, g0_q, g1_q, den_q;
  logic              lt_q, gt_q;

  // Stage 2 output registers.
  logic              v2_q;
  logic [SAMPLE_BITS:0] num_q, dn_q;
  logic [1:0]        mode_q;
  logic [FRACTION_BITS:0] frac_q;
  logic [2:0]        pick_q;
  logic              degen_q;

  logic adv2, adv1;
  assign adv2 = !v2_q || job_ready_i;
  assign adv1 = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      sd0_q <= W'(iso_i) - W'(s0_i);
      sd1_q <= W'(iso_i) - W'(s1_i);
      ng1_q <= -W'(g1_i);
      g0_q  <= W'(g0_i);
      g1_q  <= W'(g1_i);
      den_q <= W'(s1_i) - W'(s0_i);
      lt_q  <= s0_i < s1_i;
      gt_q  <= s0_i > s1_i;
    end
  end

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
    absw = v[W-1] ? -v : v;
  endfunction

  // Plane test: on edge, exact one, or zero distance.
  logic in0, in1, one0, one1, in_both;
  logic [W-1:0] an0, ag0, an1, ag1, anl, adl;
  logic numl_neg;
  always_comb begin
    an0 = absw(sd0_q);
    ag0 = absw(g0_q);
    an1 = absw(sd1_q);
    ag1 = absw(ng1_q);
    in0 = (sd0_q == '0) ||
          ((sd0_q[W-1] == g0_q[W-1]) && (g0_q != '0) && (ag0 >= an0));
    in1 = (sd1_q == '0) ||
          ((sd1_q[W-1] == ng1_q[W-1]) && (ng1_q != '0) && (ag1 >= an1));
    one0 = (sd0_q != '0) && (ag0 == an0);
    one1 = (sd1_q != '0) && (ag1 == an1);
    in_both = in0 && in1;
    // t0 vs t1 sign rule needs both fractions; it is decided in the back end.
    // Linear numerator sign after flipping to a positive denominator; both
    // sd0 and den are nonzero on that path.
    numl_neg = den_q[W-1] ^ sd0_q[W-1];
    anl = absw(sd0_q);
    adl = absw(den_q);
  end

  // Classify the edge; when both planes are valid the back end needs both quotients.
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      degen_q <= 1'b0;
      frac_q  <= '0;
      num_q   <= '0;
      dn_q    <= '0;
      mode_q  <= DIV_NONE;
      if (sd0_q == '0) begin
        pick_q <= PICK_END0;
      end else if (sd1_q == '0) begin
        pick_q <= PICK_END1;
        frac_q <= One;
      end else if (in_both) begin
        pick_q <= PICK_PLANE0;
        mode_q <= DIV_BOTH;
        num_q  <= an0[SAMPLE_BITS:0];
        dn_q   <= ag0[SAMPLE_BITS:0];
        frac_q <= {lt_q, gt_q, (g0_q > g1_q), {(FRACTION_BITS-2){1'b0}}};
      end else if (in0) begin
        pick_q <= PICK_PLANE0;
        if (one0) frac_q <= One;
        else begin
          mode_q <= DIV_PLAIN;
          num_q  <= an0[SAMPLE_BITS:0];
          dn_q   <= ag0[SAMPLE_BITS:0];
        end
      end else if (in1) begin
        pick_q <= PICK_PLANE1;
        if (!one1) begin
          mode_q <= DIV_INV;
          num_q  <= an1[SAMPLE_BITS:0];
          dn_q   <= ag1[SAMPLE_BITS:0];
        end
      end else begin
        pick_q <= PICK_LINEAR;
        if (den_q == '0) degen_q <= 1'b1;
        else if (numl_neg) frac_q <= '0;
        else if (anl >= adl) frac_q <= One;
        else begin
          mode_q <= DIV_PLAIN;
          num_q  <= anl[SAMPLE_BITS:0];
          dn_q   <= adl[SAMPLE_BITS:0];
        end
      end
    end
  end

  // Second plane operands for the both-valid case; equal operands divide to one.
  logic [SAMPLE_BITS:0] n1_q, d1_q;
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      n1_q <= an1[SAMPLE_BITS:0];
      d1_q <= ag1[SAMPLE_BITS:0];
    end
  end

  assign job_valid_o = v2_q;
  assign job_num_a_o = num_q;
  assign job_den_a_o = dn_q;
  assign job_num_o   = (mode_q == DIV_BOTH) ? n1_q : num_q;
  assign job_den_o   = (mode_q == DIV_BOTH) ? d1_q : dn_q;
  assign job_mode_o  = mode_q;
  assign job_frac_o  = frac_q;
  assign job_pick_o  = pick_q;
  assign job_degen_o = degen_q;
endmodule
`default_nettype wire

// ===== design/gecs_back.sv =====
// Back end: pipelined restoring dividers and final selection.
`default_nettype none
module gecs_back #(
  parameter int FRACTION_BITS = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  logic [SAMPLE_BITS:0]   num_a_i,
  input  logic [SAMPLE_BITS:0]   den_a_i,
  input  logic [SAMPLE_BITS:0]   num_b_i,
  input  logic [SAMPLE_BITS:0]   den_b_i,
  input  logic [1:0]             mode_i,
  input  logic [FRACTION_BITS:0] frac_i,
  input  logic [2:0]             pick_i,
  input  logic                   degen_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [FRACTION_BITS:0] frac_o,
  output logic [2:0]             pick_o,
  output logic                   degen_o
);
  import gecs_pkg::*;

  // One quotient bit per stage; FRACTION_BITS+1 stages, then finish stage.
  localparam int N  = FRACTION_BITS + 1;
  localparam int RW = SAMPLE_BITS + 2;
  localparam logic [FRACTION_BITS:0] One = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                   v_q   [N+1];
  logic [RW-1:0]          ra_q  [N+1];
  logic [RW-1:0]          rb_q  [N+1];
  logic [SAMPLE_BITS:0]   da_q  [N+1];
  logic [SAMPLE_BITS:0]   db_q  [N+1];
  logic [N-1:0]           qa_q  [N+1];
  logic [N-1:0]           qb_q  [N+1];
  logic [1:0]             m_q   [N+1];
  logic [FRACTION_BITS:0] f_q   [N+1];
  logic [2:0]             p_q   [N+1];
  logic                   dg_q  [N+1];

  logic adv;
  assign adv = !out_valid_o || out_ready_i;
  assign job_ready_o = adv;

  // Rounding: round(n*2^F/d) with halves up equals (floor(n*2^(F+1)/d) + 1) >> 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= N; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= job_valid_i;
      for (int i = 1; i <= N; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Restoring long division of n*2^N by d, n <= d: remainder starts at n,
  // each stage doubles it and subtracts d when it fits.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_q[0] <= RW'(num_a_i);
      rb_q[0] <= RW'(num_b_i);
      da_q[0] <= den_a_i;
      db_q[0] <= den_b_i;
      qa_q[0] <= '0;
      qb_q[0] <= '0;
      m_q[0]  <= mode_i;
      f_q[0]  <= frac_i;
      p_q[0]  <= pick_i;
      dg_q[0] <= degen_i;
      for (int i = 1; i <= N; i++) begin
        m_q[i]  <= m_q[i-1];
        f_q[i]  <= f_q[i-1];
        p_q[i]  <= p_q[i-1];
        dg_q[i] <= dg_q[i-1];
        da_q[i] <= da_q[i-1];
        db_q[i] <= db_q[i-1];
        if ({ra_q[i-1], 1'b0} >= {1'b0, RW'(da_q[i-1])}) begin
          ra_q[i] <= RW'({ra_q[i-1], 1'b0} - {1'b0, RW'(da_q[i-1])});
          qa_q[i] <= {qa_q[i-1][N-2:0], 1'b1};
        end else begin
          ra_q[i] <= RW'({ra_q[i-1], 1'b0});
          qa_q[i] <= {qa_q[i-1][N-2:0], 1'b0};
        end
        if ({rb_q[i-1], 1'b0} >= {1'b0, RW'(db_q[i-1])}) begin
          rb_q[i] <= RW'({rb_q[i-1], 1'b0} - {1'b0, RW'(db_q[i-1])});
          qb_q[i] <= {qb_q[i-1][N-2:0], 1'b1};
        end else begin
          rb_q[i] <= RW'({rb_q[i-1], 1'b0});
          qb_q[i] <= {qb_q[i-1][N-2:0], 1'b0};
        end
      end
    end
  end

  // floor(n*2^(F+1)/d) -> round = (q+1)>>1.
  logic [FRACTION_BITS:0] ta, tb, t0, t1;
  logic [N:0] sa, sb;
  logic pick1;
  always_comb begin
    sa = {1'b0, qa_q[N]} + 1'b1;
    sb = {1'b0, qb_q[N]} + 1'b1;
    ta = sa[N:1];
    tb = sb[N:1];
    t0 = ta;
    t1 = One - tb;
    // lt, gt, g0>g1 flags ride in frac
    if (f_q[N][FRACTION_BITS])
      pick1 = f_q[N][FRACTION_BITS-2] ? (t0 < t1) : (t0 > t1);
    else if (f_q[N][FRACTION_BITS-1])
      pick1 = f_q[N][FRACTION_BITS-2] ? (t0 > t1) : (t0 < t1);
    else
      pick1 = 1'b0;
  end

  logic                   ov_q;
  logic [FRACTION_BITS:0] of_q;
  logic [2:0]             op_q;
  logic                   od_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= v_q[N];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q <= dg_q[N];
      unique case (m_q[N])
        DIV_NONE:  begin of_q <= f_q[N]; op_q <= p_q[N]; end
        DIV_PLAIN: begin of_q <= ta; op_q <= p_q[N]; end
        DIV_INV:   begin of_q <= One - tb; op_q <= p_q[N]; end
        DIV_BOTH: begin
          of_q <= pick1 ? t1 : t0;
          op_q <= pick1 ? PICK_PLANE1 : PICK_PLANE0;
        end
      endcase
    end
  end
  assign out_valid_o = ov_q;
  assign frac_o  = of_q;
  assign pick_o  = op_q;
  assign degen_o = od_q;
endmodule
`default_nettype wire

// ===== design/gradient_edge_crossing_select.sv =====
// Top level: edge crossing fraction with tangent-plane selection.
//  channel | signals                                  | dir
//  in      | in_valid_i/in_ready_o, scalar/grad ports | in
//  out     | out_valid_o/out_ready_i, result ports    | out
//  cfg     | cfg_we_i, cfg_wdata_i (iso_level)        | in
// One edge per cycle while the output is not stalled; the result passes
// two front stages, FRACTION_BITS+2 divider stages and the output register.
// Reset clears all valids and sets iso_level to 0. The back end advances
// only when the output register is empty or taken; the front end keeps
// accepting until both of its stages are full and the back end stalls.
`default_nettype none
module gradient_edge_crossing_select #(
  parameter int FRACTION_BITS = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic signed [SAMPLE_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] scalar_v0_i,
  input  logic signed [SAMPLE_BITS-1:0] scalar_v1_i,
  input  logic signed [SAMPLE_BITS-1:0] grad_v0_i,
  input  logic signed [SAMPLE_BITS-1:0] grad_v1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [FRACTION_BITS:0]        edge_fraction_o,
  output logic [2:0]                    pick_o,
  output logic                          degenerate_o
);
  import gecs_pkg::*;

  logic signed [SAMPLE_BITS-1:0] iso_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iso_q <= '0;
    else if (cfg_we_i) iso_q <= cfg_wdata_i;
  end

  logic job_valid, job_ready, job_degen;
  logic [SAMPLE_BITS:0] job_num_a, job_den_a, job_num, job_den;
  logic [1:0] job_mode;
  logic [FRACTION_BITS:0] job_frac;
  logic [2:0] job_pick;

  gecs_front #(.FRACTION_BITS(FRACTION_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .iso_i(iso_q),
    .in_valid_i, .in_ready_o,
    .s0_i(scalar_v0_i), .s1_i(scalar_v1_i), .g0_i(grad_v0_i), .g1_i(grad_v1_i),
    .job_valid_o(job_valid), .job_ready_i(job_ready),
    .job_num_a_o(job_num_a), .job_den_a_o(job_den_a),
    .job_num_o(job_num), .job_den_o(job_den), .job_mode_o(job_mode),
    .job_frac_o(job_frac), .job_pick_o(job_pick), .job_degen_o(job_degen)
  );

  gecs_back #(.FRACTION_BITS(FRACTION_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready),
    .num_a_i(job_num_a), .den_a_i(job_den_a),
    .num_b_i(job_num), .den_b_i(job_den),
    .mode_i(job_mode), .frac_i(job_frac), .pick_i(job_pick), .degen_i(job_degen),
    .out_valid_o, .out_ready_i,
    .frac_o(edge_fraction_o), .pick_o, .degen_o(degenerate_o)
  );
endmodule
`default_nettype wire

// ===== design/gecs_checker.sv =====
// Port-level checks for the edge crossing block, bound to the top level.
`default_nettype none
module gecs_checker #(
  parameter int FRACTION_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [FRACTION_BITS:0] edge_fraction_o,
  input logic [2:0]             pick_o,
  input logic                   degenerate_o
);
  import gecs_pkg::*;

  localparam logic [FRACTION_BITS:0] One = {1'b1, {FRACTION_BITS{1'b0}}};

  a_pick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pick_o <= PICK_LINEAR) else $error("pick out of range");
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> edge_fraction_o <= One) else $error("fraction too large");
  a_degen_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (pick_o == PICK_LINEAR && edge_fraction_o == '0))
    else $error("degenerate outside linear");
  a_end0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pick_o == PICK_END0) |-> edge_fraction_o == '0)
    else $error("end0 fraction");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(edge_fraction_o)))
    else $error("output dropped while stalled");
endmodule

bind gradient_edge_crossing_select gecs_checker #(.FRACTION_BITS(FRACTION_BITS))
  u_gecs_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i,
  .edge_fraction_o, .pick_o, .degenerate_o
);
`default_nettype wire
